/* rtl/core/sjf_pkg.sv */
// Shared types and fixed field widths for the shortest-job-first scheduler.
// No dependencies; imported by every module of the block.
package sjf_pkg;

  // Fixed widths of the stream fields
  localparam int BURST_IN_W  = 16;
  localparam int POS_OUT_W   = 6;
  localparam int TIME_OUT_W  = 22;
  localparam int TOTAL_OUT_W = 28;
  localparam int OUT_FIELDS_W = POS_OUT_W + 2 * TIME_OUT_W + 2 * TOTAL_OUT_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  // Front-end status seen by the back end
  typedef struct packed {
    logic batch_ready;  // sorted batch complete, waiting for hand-over
    logic dropped;      // batch lost tasks to capacity
  } fe_status_t;

endpackage

/* rtl/core/shortest_job_first_schedule_unit.sv */
// Shortest-job-first batch scheduler, top level. Uses sjf_pkg, sjf_front, sjf_back.
// Throughput: one task word per cycle; after a final task word the input stalls for the
// hand-over and, while the previous batch is still draining, until that batch has drained.
// Results: after the hand-over the drain bank emits registered result words, one per cycle unless m_axis_tready stalls.
// Reset (rst, synchronous): empties the chain and the drain bank, no memory sweep.
module shortest_job_first_schedule_unit
  import sjf_pkg::*;
#(
  parameter int MAX_TASKS  = 64,
  parameter int BURST_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [BURST_IN_W-1:0]  s_axis_tdata,   // [15:0] burst_length
  input  logic                   s_axis_tlast,   // final_task
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [5:0] task_position, [27:6] wait_time,
                                                 // [49:28] turnaround_time,
                                                 // [77:50] wait_total,
                                                 // [105:78] turnaround_total, zero pad
  output logic                   m_axis_tlast,   // end_of_schedule
  output logic                   m_axis_tuser    // tasks_dropped
);

  localparam int CW = $clog2(MAX_TASKS + 1);
  localparam int PW = $clog2(MAX_TASKS);

  fe_status_t             status;
  logic                   take;
  logic [CW-1:0]          count;
  logic [BURST_BITS-1:0]  chain_burst [MAX_TASKS];
  logic [PW-1:0]          chain_pos [MAX_TASKS];
  logic [POS_OUT_W-1:0]   out_pos;
  logic [TIME_OUT_W-1:0]  out_wait;
  logic [TIME_OUT_W-1:0]  out_tat;
  logic [TOTAL_OUT_W-1:0] out_wait_total;
  logic [TOTAL_OUT_W-1:0] out_tat_total;

  // sorting front end
  sjf_front #(
    .MAX_TASKS (MAX_TASKS),
    .BURST_BITS(BURST_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_burst   (s_axis_tdata),
    .in_last    (s_axis_tlast),
    .take       (take),
    .status     (status),
    .count      (count),
    .chain_burst(chain_burst),
    .chain_pos  (chain_pos)
  );

  // draining back end
  sjf_back #(
    .MAX_TASKS (MAX_TASKS),
    .BURST_BITS(BURST_BITS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .status        (status),
    .count         (count),
    .chain_burst   (chain_burst),
    .chain_pos     (chain_pos),
    .take          (take),
    .out_valid     (m_axis_tvalid),
    .out_ready     (m_axis_tready),
    .out_pos       (out_pos),
    .out_wait      (out_wait),
    .out_tat       (out_tat),
    .out_wait_total(out_wait_total),
    .out_tat_total (out_tat_total),
    .out_last      (m_axis_tlast),
    .out_dropped   (m_axis_tuser)
  );

  // pack the result word, first field lowest
  assign m_axis_tdata = {
    {(OUT_TDATA_W - OUT_FIELDS_W){1'b0}},
    out_tat_total,
    out_wait_total,
    out_tat,
    out_wait,
    out_pos
  };

endmodule

/* rtl/core/sjf_front.sv */
// Front end: accepts tasks and keeps them in an insertion-sorted register chain.
// Depends on sjf_pkg; hands a completed batch to sjf_back.
module sjf_front
  import sjf_pkg::*;
#(
  parameter int MAX_TASKS  = 64,
  parameter int BURST_BITS = 16,
  localparam int CW = $clog2(MAX_TASKS + 1),
  localparam int PW = $clog2(MAX_TASKS)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [BURST_IN_W-1:0] in_burst,
  input  logic                  in_last,
  input  logic                  take,
  output fe_status_t            status,
  output logic [CW-1:0]         count,
  output logic [BURST_BITS-1:0] chain_burst [MAX_TASKS],
  output logic [PW-1:0]         chain_pos [MAX_TASKS]
);

  logic                          batch_ready;
  logic                          dropped;
  logic                          accept;
  logic                          insert;
  logic [BURST_BITS+BURST_IN_W-1:0] burst_ext;
  logic [BURST_BITS-1:0]         burst;
  logic [PW+CW-1:0]              pos_ext;
  logic [PW-1:0]                 new_pos;
  logic [MAX_TASKS-1:0]          gt;

  assign in_ready = !batch_ready;
  assign accept   = in_valid && in_ready;
  assign insert   = accept && (count < CW'(MAX_TASKS));

  // only the low BURST_BITS of the burst are used
  assign burst_ext = {{BURST_BITS{1'b0}}, in_burst};
  assign burst     = burst_ext[BURST_BITS-1:0];
  assign pos_ext   = {{PW{1'b0}}, count};
  assign new_pos   = pos_ext[PW-1:0];

  // cells holding a strictly larger burst move up by one
  always_comb begin
    for (int i = 0; i < MAX_TASKS; i++) begin
      gt[i] = (CW'(i) < count) && (chain_burst[i] > burst);
    end
  end

  assign status.batch_ready = batch_ready;
  assign status.dropped     = dropped;

  // sorted chain payload
  always_ff @(posedge clk) begin
    if (insert) begin
      for (int i = 0; i < MAX_TASKS; i++) begin
        if (gt[i]) begin
          if (i > 0 && gt[(i > 0) ? i - 1 : 0]) begin
            chain_burst[i] <= chain_burst[(i > 0) ? i - 1 : 0];
            chain_pos[i]   <= chain_pos[(i > 0) ? i - 1 : 0];
          end else begin
            chain_burst[i] <= burst;
            chain_pos[i]   <= new_pos;
          end
        end else if (CW'(i) == count) begin
          // first free cell takes the top entry when it moves up, else the new task
          if (i > 0 && gt[(i > 0) ? i - 1 : 0]) begin
            chain_burst[i] <= chain_burst[(i > 0) ? i - 1 : 0];
            chain_pos[i]   <= chain_pos[(i > 0) ? i - 1 : 0];
          end else begin
            chain_burst[i] <= burst;
            chain_pos[i]   <= new_pos;
          end
        end
      end
    end
  end

  // batch control
  always_ff @(posedge clk) begin
    if (rst) begin
      count       <= '0;
      dropped     <= 1'b0;
      batch_ready <= 1'b0;
    end else if (take) begin
      count       <= '0;
      dropped     <= 1'b0;
      batch_ready <= 1'b0;
    end else if (accept) begin
      if (insert) begin
        count <= count + 1'b1;
      end else begin
        dropped <= 1'b1;
      end
      batch_ready <= in_last;
    end
  end

endmodule

/* rtl/core/sjf_back.sv */
// Back end: holds a handed-over sorted batch and drains it one result per cycle while
// the output is not stalled, with running wait and turnaround sums. Depends on sjf_pkg.
module sjf_back
  import sjf_pkg::*;
#(
  parameter int MAX_TASKS  = 64,
  parameter int BURST_BITS = 16,
  localparam int CW     = $clog2(MAX_TASKS + 1),
  localparam int PW     = $clog2(MAX_TASKS),
  localparam int WAIT_W = BURST_BITS + CW,
  localparam int SUM_W  = BURST_BITS + 2 * CW
) (
  input  logic                   clk,
  input  logic                   rst,
  input  fe_status_t             status,
  input  logic [CW-1:0]          count,
  input  logic [BURST_BITS-1:0]  chain_burst [MAX_TASKS],
  input  logic [PW-1:0]          chain_pos [MAX_TASKS],
  output logic                   take,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [POS_OUT_W-1:0]   out_pos,
  output logic [TIME_OUT_W-1:0]  out_wait,
  output logic [TIME_OUT_W-1:0]  out_tat,
  output logic [TOTAL_OUT_W-1:0] out_wait_total,
  output logic [TOTAL_OUT_W-1:0] out_tat_total,
  output logic                   out_last,
  output logic                   out_dropped
);

  logic                  busy;
  logic [CW-1:0]         remain;
  logic                  dropped;
  logic [BURST_BITS-1:0] bank_burst [MAX_TASKS];
  logic [PW-1:0]         bank_pos [MAX_TASKS];
  logic [WAIT_W-1:0]     wait_acc;
  logic [SUM_W-1:0]      wsum_acc;
  logic [SUM_W-1:0]      tsum_acc;
  logic [WAIT_W-1:0]     tat_next;
  logic [SUM_W-1:0]      wsum_next;
  logic [SUM_W-1:0]      tsum_next;
  logic                  emit;
  logic                  last;
  logic [PW+POS_OUT_W-1:0]    pos_ext;
  logic [WAIT_W+TIME_OUT_W-1:0] wait_ext;
  logic [WAIT_W+TIME_OUT_W-1:0] tat_ext;
  logic [SUM_W+TOTAL_OUT_W-1:0] wsum_ext;
  logic [SUM_W+TOTAL_OUT_W-1:0] tsum_ext;

  assign take = status.batch_ready && !busy;
  assign emit = busy && (!out_valid || out_ready);
  assign last = (remain == CW'(1));

  // running sums for the head entry
  assign tat_next  = wait_acc + WAIT_W'(bank_burst[0]);
  assign wsum_next = wsum_acc + SUM_W'(wait_acc);
  assign tsum_next = tsum_acc + SUM_W'(wait_acc) + SUM_W'(bank_burst[0]);

  // resize to the fixed output field widths
  assign pos_ext  = {{POS_OUT_W{1'b0}}, bank_pos[0]};
  assign wait_ext = {{TIME_OUT_W{1'b0}}, wait_acc};
  assign tat_ext  = {{TIME_OUT_W{1'b0}}, tat_next};
  assign wsum_ext = {{TOTAL_OUT_W{1'b0}}, wsum_next};
  assign tsum_ext = {{TOTAL_OUT_W{1'b0}}, tsum_next};

  // batch bank: load on hand-over, shift down one entry per result
  always_ff @(posedge clk) begin
    if (take) begin
      for (int i = 0; i < MAX_TASKS; i++) begin
        bank_burst[i] <= chain_burst[i];
        bank_pos[i]   <= chain_pos[i];
      end
    end else if (emit) begin
      for (int i = 0; i < MAX_TASKS - 1; i++) begin
        bank_burst[i] <= bank_burst[i+1];
        bank_pos[i]   <= bank_pos[i+1];
      end
    end
  end

  // accumulators and output word payload
  always_ff @(posedge clk) begin
    if (take) begin
      wait_acc <= '0;
      wsum_acc <= '0;
      tsum_acc <= '0;
      dropped  <= status.dropped;
    end else if (emit) begin
      wait_acc       <= tat_next;
      wsum_acc       <= wsum_next;
      tsum_acc       <= tsum_next;
      out_pos        <= pos_ext[POS_OUT_W-1:0];
      out_wait       <= wait_ext[TIME_OUT_W-1:0];
      out_tat        <= tat_ext[TIME_OUT_W-1:0];
      out_wait_total <= last ? wsum_ext[TOTAL_OUT_W-1:0] : '0;
      out_tat_total  <= last ? tsum_ext[TOTAL_OUT_W-1:0] : '0;
      out_last       <= last;
      out_dropped    <= dropped;
    end
  end

  // drain control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      remain    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (take) begin
        busy   <= 1'b1;
        remain <= count;
      end else if (emit) begin
        remain <= remain - 1'b1;
        if (last) begin
          busy <= 1'b0;
        end
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

/* tb/sv/shortest_job_first_schedule_unit_tb.sv */
// Self-checking testbench for the shortest-job-first batch scheduler.
// It drives task words in, predicts the sorted schedule itself and checks every result word.
// Depends on sjf_pkg and shortest_job_first_schedule_unit.
module shortest_job_first_schedule_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sjf_pkg::*;

  localparam int CAPACITY    = 64;
  localparam int IDLE_PCT    = 21;
  localparam int ITEM_TARGET = 470;
  localparam int CYCLE_LIMIT = 400000;
  localparam int MAX_REPORTS = 10;
  localparam int SETTLE      = 16;

  // Bit offsets of the result fields in m_axis_tdata
  localparam int WAIT_LO = POS_OUT_W;
  localparam int TAT_LO  = WAIT_LO + TIME_OUT_W;
  localparam int WSUM_LO = TAT_LO + TIME_OUT_W;
  localparam int TSUM_LO = WSUM_LO + TOTAL_OUT_W;

  typedef struct packed {
    logic [POS_OUT_W-1:0]   position;
    logic [TIME_OUT_W-1:0]  waited;
    logic [TIME_OUT_W-1:0]  turnaround;
    logic                   closing;
    logic [TOTAL_OUT_W-1:0] waited_sum;
    logic [TOTAL_OUT_W-1:0] turnaround_sum;
    logic                   dropped;
  } sjf_result_t;

  logic                   clk;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [BURST_IN_W-1:0]  s_axis_tdata = '0;
  logic                   s_axis_tlast = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tlast;
  logic                   m_axis_tuser;

  // Predictor state: the sorted chain as the block should hold it
  logic [BURST_IN_W-1:0] chain_burst [CAPACITY];
  logic [POS_OUT_W-1:0]  chain_pos [CAPACITY];
  int                    held_tasks = 0;
  bit                    batch_overflowed = 1'b0;

  sjf_result_t pending_results [$];
  int          fault_count = 0;
  int          tasks_sent = 0;
  int          cycle_count = 0;
  bit          steady = 1'b0;

  shortest_job_first_schedule_unit #(
    .MAX_TASKS  (CAPACITY),
    .BURST_BITS (BURST_IN_W)
  ) dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("simulation failed");
    $finish;
  end

  function automatic void note_fault(input string msg);
    fault_count++;
    if (fault_count <= MAX_REPORTS) $display("%s", msg);
  endfunction

  function automatic string show_result(input sjf_result_t r);
    return $sformatf("pos=%0d wait=%0d tat=%0d last=%0b wsum=%0d tsum=%0d drop=%0b",
                     r.position, r.waited, r.turnaround, r.closing,
                     r.waited_sum, r.turnaround_sum, r.dropped);
  endfunction

  // Insert one accepted task into the chain; a final task releases the whole schedule
  task automatic schedule_task(input logic [BURST_IN_W-1:0] burst, input logic fin);
    int          slot;
    int unsigned elapsed;
    int unsigned tat;
    int unsigned wsum;
    int unsigned tsum;
    sjf_result_t r;
    if (held_tasks >= CAPACITY) begin
      batch_overflowed = 1'b1;
    end else begin
      // stable insert: goes after every entry with an equal or shorter burst
      slot = held_tasks;
      while (slot > 0 && chain_burst[slot-1] > burst) begin
        chain_burst[slot] = chain_burst[slot-1];
        chain_pos[slot]   = chain_pos[slot-1];
        slot--;
      end
      chain_burst[slot] = burst;
      chain_pos[slot]   = held_tasks[POS_OUT_W-1:0];
      held_tasks++;
    end
    if (fin) begin
      elapsed = 0;
      wsum    = 0;
      tsum    = 0;
      for (int k = 0; k < held_tasks; k++) begin
        tat  = elapsed + chain_burst[k];
        wsum += elapsed;
        tsum += tat;
        r.position       = chain_pos[k];
        r.waited         = elapsed[TIME_OUT_W-1:0];
        r.turnaround     = tat[TIME_OUT_W-1:0];
        r.closing        = (k == held_tasks - 1);
        r.waited_sum     = r.closing ? wsum[TOTAL_OUT_W-1:0] : '0;
        r.turnaround_sum = r.closing ? tsum[TOTAL_OUT_W-1:0] : '0;
        r.dropped        = batch_overflowed;
        pending_results.push_back(r);
        elapsed = tat;
      end
      held_tasks       = 0;
      batch_overflowed = 1'b0;
    end
  endtask

  // Monitor: predict on accepted task words, check accepted result words
  always @(posedge clk) begin
    sjf_result_t got;
    sjf_result_t want;
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) schedule_task(s_axis_tdata, s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready) begin
        got.position       = m_axis_tdata[0 +: POS_OUT_W];
        got.waited         = m_axis_tdata[WAIT_LO +: TIME_OUT_W];
        got.turnaround     = m_axis_tdata[TAT_LO +: TIME_OUT_W];
        got.closing        = m_axis_tlast;
        got.waited_sum     = m_axis_tdata[WSUM_LO +: TOTAL_OUT_W];
        got.turnaround_sum = m_axis_tdata[TSUM_LO +: TOTAL_OUT_W];
        got.dropped        = m_axis_tuser;
        if (pending_results.size() == 0) begin
          note_fault({"unexpected result word: ", show_result(got)});
        end else begin
          want = pending_results.pop_front();
          if (got !== want)
            note_fault({"result mismatch\n  expected ", show_result(want),
                        "\n  actual   ", show_result(got)});
        end
      end
    end
  end

  // Result side back-pressure
  always @(posedge clk) begin
    m_axis_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
  end

  // Send one task word, with random gaps unless the stream is held steady
  task automatic send_task(input logic [BURST_IN_W-1:0] burst, input logic fin);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= burst;
    s_axis_tlast  <= fin;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    tasks_sent++;
  endtask

  // Mix of tie-heavy small values, extremes and full-range bursts
  function automatic logic [BURST_IN_W-1:0] pick_burst();
    int unsigned mode;
    mode = $urandom_range(99);
    if (mode < 25) return BURST_IN_W'($urandom_range(3));
    if (mode < 30) return '0;
    if (mode < 35) return '1;
    return BURST_IN_W'($urandom_range(65535));
  endfunction

  task automatic send_batch(input int size);
    for (int i = 0; i < size; i++) send_task(pick_burst(), i == size - 1);
  endtask

  // Hold the sender off until every predicted result has come back
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_single_task();
    send_task(16'h0000, 1'b1);
    send_task(16'hFFFF, 1'b1);
    drain_results();
  endtask

  task automatic test_sort_order();
    // descending bursts, fully reversed by the chain
    send_task(16'hFFFF, 1'b0);
    send_task(16'h5555, 1'b0);
    send_task(16'h0007, 1'b0);
    send_task(16'h0000, 1'b1);
    // ascending bursts, order kept
    send_task(16'h0001, 1'b0);
    send_task(16'h5555, 1'b0);
    send_task(16'hAAAA, 1'b1);
    drain_results();
  endtask

  task automatic test_ties_stable();
    send_task(16'd5, 1'b0);
    send_task(16'd5, 1'b0);
    send_task(16'd2, 1'b0);
    send_task(16'd5, 1'b0);
    send_task(16'd2, 1'b0);
    send_task(16'hFFFF, 1'b0);
    send_task(16'd2, 1'b1);
    drain_results();
  endtask

  task automatic test_capacity();
    // exactly full, then one over with the final word dropped, then two over
    send_batch(CAPACITY);
    drain_results();
    send_batch(CAPACITY + 1);
    drain_results();
    for (int i = 0; i < CAPACITY; i++) send_task(16'hFFFF, 1'b0);
    send_task(16'hFFFF, 1'b0);
    send_task(16'h0000, 1'b1);
    drain_results();
  endtask

  task automatic test_steady_stream();
    steady = 1'b1;
    for (int b = 0; b < 12; b++) send_batch($urandom_range(1, 8));
    drain_results();
    steady = 1'b0;
  endtask

  task automatic test_random_batches();
    int unsigned pick;
    while (tasks_sent < ITEM_TARGET) begin
      pick = $urandom_range(99);
      if (pick < 80)      send_batch($urandom_range(1, 8));
      else if (pick < 95) send_batch($urandom_range(9, 40));
      else                send_batch($urandom_range(CAPACITY - 1, CAPACITY + 4));
      if ($urandom_range(9) == 0) drain_results();
    end
    drain_results();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_single_task();
    test_sort_order();
    test_ties_stable();
    test_capacity();
    test_steady_stream();
    test_random_batches();
    repeat (SETTLE) @(posedge clk);
    if (pending_results.size() != 0)
      note_fault($sformatf("%0d expected result words never arrived",
                           pending_results.size()));
    if (fault_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
